>>> hdl/fat16_boot_sector_checker_macros.svh
// Assertion macros used by the FAT16 boot sector checker assertions
`ifndef FAT16_BOOT_SECTOR_CHECKER_MACROS_SVH
`define FAT16_BOOT_SECTOR_CHECKER_MACROS_SVH

// Property checked on every clock edge, masked while reset is asserted
`define F16BS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked on every clock edge, reset included
`define F16BS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hdl/fat16bs_pkg.sv
// Types and constants of the FAT16 boot sector checker
`timescale 1ns / 1ps

package fat16bs_pkg;

  localparam int SECTOR_BYTES    = 512;
  localparam int DIR_ENTRY_BYTES = 32;
  localparam int SECTOR_SHIFT    = $clog2(SECTOR_BYTES);
  localparam int DIR_SHIFT       = $clog2(SECTOR_BYTES / DIR_ENTRY_BYTES);

  localparam logic [7:0] JMP_SHORT = 8'hEB;
  localparam logic [7:0] JMP_NOP   = 8'h90;
  localparam logic [7:0] JMP_NEAR  = 8'hE9;

  localparam logic [31:0] MIN_CLUSTERS      = 32'd4085;
  localparam logic [31:0] MAX_CLUSTERS_EXCL = 32'd65525;

  // byte offsets within the boot sector
  localparam logic [5:0] OFF_JUMP     = 6'd0;
  localparam logic [5:0] OFF_NOP      = 6'd2;
  localparam logic [5:0] OFF_BPS_LO   = 6'd11;
  localparam logic [5:0] OFF_BPS_HI   = 6'd12;
  localparam logic [5:0] OFF_SPC      = 6'd13;
  localparam logic [5:0] OFF_RSVD_LO  = 6'd14;
  localparam logic [5:0] OFF_RSVD_HI  = 6'd15;
  localparam logic [5:0] OFF_NFATS    = 6'd16;
  localparam logic [5:0] OFF_ROOT_LO  = 6'd17;
  localparam logic [5:0] OFF_ROOT_HI  = 6'd18;
  localparam logic [5:0] OFF_SMALL_LO = 6'd19;
  localparam logic [5:0] OFF_SMALL_HI = 6'd20;
  localparam logic [5:0] OFF_FATSZ_LO = 6'd22;
  localparam logic [5:0] OFF_FATSZ_HI = 6'd23;
  localparam logic [5:0] OFF_LARGE_B0 = 6'd32;
  localparam logic [5:0] OFF_LARGE_B1 = 6'd33;
  localparam logic [5:0] OFF_LARGE_B2 = 6'd34;
  localparam logic [5:0] OFF_LARGE_B3 = 6'd35;
  localparam logic [5:0] OFF_LAST     = 6'd38;

  typedef enum logic [2:0] {
    ST_OK               = 3'd0,
    ST_BAD_JUMP         = 3'd1,
    ST_BAD_SECTOR_SIZE  = 3'd2,
    ST_BAD_CLUSTER_SIZE = 3'd3,
    ST_BAD_SECTOR_COUNT = 3'd4,
    ST_NOT_FAT16        = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0]  spc;
    logic [15:0] reserved;
    logic [7:0]  fat_copies;
    logic [15:0] root_entries;
    logic [15:0] small_count;
    logic [15:0] fat_sectors;
    logic [31:0] large_count;
  } bpb_t;

  typedef struct packed {
    logic [33:0] fat_start;
    logic [33:0] root_start;
    logic [33:0] data_start;
    logic [31:0] data_secs;
  } layout_t;

  typedef struct packed {
    status_t     status;
    logic [33:0] fat_region_start;
    logic [33:0] root_region_start;
    logic [33:0] data_region_start;
    logic [31:0] cluster_count;
  } result_t;

endpackage

>>> hdl/fat16bs_if.sv
// Byte input and result channel interfaces
`timescale 1ns / 1ps

interface fat16bs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;

  modport source (output valid, output data_byte, output first_byte, input ready);
  modport sink (input valid, input data_byte, input first_byte, output ready);
endinterface

interface fat16bs_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [33:0] fat_region_start;
  logic [33:0] root_region_start;
  logic [33:0] data_region_start;
  logic [31:0] cluster_count;

  modport source (output valid, output status, output fat_region_start,
                  output root_region_start, output data_region_start,
                  output cluster_count, input ready);
  modport sink (input valid, input status, input fat_region_start,
                input root_region_start, input data_region_start,
                input cluster_count, output ready);
endinterface

>>> hdl/fat16bs_parse.sv
// Byte offset tracking, BPB field capture and header checks
`timescale 1ns / 1ps

module fat16bs_parse (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 acc,
  input  logic [7:0]           data_byte,
  input  logic                 first_byte,
  input  fat16bs_pkg::layout_t layout,
  output fat16bs_pkg::bpb_t    bpb,
  output logic                 res_valid,
  output fat16bs_pkg::result_t res
);

  logic [5:0]        off_r, off_nxt, cur_off;
  logic              finished_r, finished_nxt;
  logic              jump_short_r, jump_short_nxt;
  logic [7:0]        bps_lo_r, bps_lo_nxt;
  fat16bs_pkg::bpb_t bpb_r, bpb_nxt;
  logic [2:0]        shamt;
  logic [31:0]       clusters;

  // sectors per cluster is a checked power of two by the time it is used
  always_comb begin
    shamt = '0;
    for (int i = 0; i < 8; i++) begin
      if (bpb_r.spc[i]) shamt = 3'(i);
    end
    clusters = layout.data_secs >> shamt;
  end

  always_comb begin
    off_nxt        = off_r;
    finished_nxt   = finished_r;
    jump_short_nxt = jump_short_r;
    bps_lo_nxt     = bps_lo_r;
    bpb_nxt        = bpb_r;
    cur_off        = first_byte ? fat16bs_pkg::OFF_JUMP : off_r;
    res_valid      = 1'b0;
    res            = '0;
    if (acc && (first_byte || !finished_r)) begin
      off_nxt      = cur_off + 6'd1;
      finished_nxt = 1'b0;
      case (cur_off)
        fat16bs_pkg::OFF_JUMP: begin
          if (data_byte == fat16bs_pkg::JMP_SHORT) begin
            jump_short_nxt = 1'b1;
          end else if (data_byte == fat16bs_pkg::JMP_NEAR) begin
            jump_short_nxt = 1'b0;
          end else begin
            res_valid  = 1'b1;
            res.status = fat16bs_pkg::ST_BAD_JUMP;
          end
        end
        fat16bs_pkg::OFF_NOP: begin
          if (jump_short_r && data_byte != fat16bs_pkg::JMP_NOP) begin
            res_valid  = 1'b1;
            res.status = fat16bs_pkg::ST_BAD_JUMP;
          end
        end
        fat16bs_pkg::OFF_BPS_LO: bps_lo_nxt = data_byte;
        fat16bs_pkg::OFF_BPS_HI: begin
          if ({data_byte, bps_lo_r} != 16'(fat16bs_pkg::SECTOR_BYTES)) begin
            res_valid  = 1'b1;
            res.status = fat16bs_pkg::ST_BAD_SECTOR_SIZE;
          end
        end
        fat16bs_pkg::OFF_SPC: begin
          bpb_nxt.spc = data_byte;
          if (data_byte == 8'd0 || (data_byte & (data_byte - 8'd1)) != 8'd0) begin
            res_valid  = 1'b1;
            res.status = fat16bs_pkg::ST_BAD_CLUSTER_SIZE;
          end
        end
        fat16bs_pkg::OFF_RSVD_LO:  bpb_nxt.reserved[7:0]     = data_byte;
        fat16bs_pkg::OFF_RSVD_HI:  bpb_nxt.reserved[15:8]    = data_byte;
        fat16bs_pkg::OFF_NFATS:    bpb_nxt.fat_copies        = data_byte;
        fat16bs_pkg::OFF_ROOT_LO:  bpb_nxt.root_entries[7:0] = data_byte;
        fat16bs_pkg::OFF_ROOT_HI:  bpb_nxt.root_entries[15:8] = data_byte;
        fat16bs_pkg::OFF_SMALL_LO: bpb_nxt.small_count[7:0]  = data_byte;
        fat16bs_pkg::OFF_SMALL_HI: bpb_nxt.small_count[15:8] = data_byte;
        fat16bs_pkg::OFF_FATSZ_LO: bpb_nxt.fat_sectors[7:0]  = data_byte;
        fat16bs_pkg::OFF_FATSZ_HI: bpb_nxt.fat_sectors[15:8] = data_byte;
        fat16bs_pkg::OFF_LARGE_B0: bpb_nxt.large_count[7:0]  = data_byte;
        fat16bs_pkg::OFF_LARGE_B1: bpb_nxt.large_count[15:8] = data_byte;
        fat16bs_pkg::OFF_LARGE_B2: bpb_nxt.large_count[23:16] = data_byte;
        fat16bs_pkg::OFF_LARGE_B3: begin
          bpb_nxt.large_count[31:24] = data_byte;
          // exactly one of the two sector counts must be nonzero
          if ((bpb_r.small_count != 16'd0) ==
              ({data_byte, bpb_r.large_count[23:0]} != 32'd0)) begin
            res_valid  = 1'b1;
            res.status = fat16bs_pkg::ST_BAD_SECTOR_COUNT;
          end
        end
        fat16bs_pkg::OFF_LAST: begin
          res_valid             = 1'b1;
          res.fat_region_start  = layout.fat_start;
          res.root_region_start = layout.root_start;
          res.data_region_start = layout.data_start;
          res.cluster_count     = clusters;
          if (clusters < fat16bs_pkg::MIN_CLUSTERS ||
              clusters >= fat16bs_pkg::MAX_CLUSTERS_EXCL) begin
            res.status = fat16bs_pkg::ST_NOT_FAT16;
          end else begin
            res.status = fat16bs_pkg::ST_OK;
          end
        end
        default: ;
      endcase
      if (res_valid) finished_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r      <= '0;
      finished_r <= 1'b1;
    end else begin
      off_r      <= off_nxt;
      finished_r <= finished_nxt;
    end
  end

  always_ff @(posedge clk) begin
    jump_short_r <= jump_short_nxt;
    bps_lo_r     <= bps_lo_nxt;
    bpb_r        <= bpb_nxt;
  end

  assign bpb = bpb_r;

endmodule

>>> hdl/fat16bs_layout.sv
// Two-stage precompute of region starts and data sector count
`timescale 1ns / 1ps

module fat16bs_layout (
  input  logic                 clk,
  input  fat16bs_pkg::bpb_t    bpb,
  output fat16bs_pkg::layout_t layout
);

  localparam logic [16:0] ROOT_ROUND = 17'((1 << fat16bs_pkg::DIR_SHIFT) - 1);

  logic [23:0] fat_secs_r, fat_secs_nxt;
  logic [12:0] root_secs_r, root_secs_nxt;
  logic [31:0] total_r, total_nxt;
  logic [15:0] reserved_r;
  logic [16:0] root_sum;
  logic [24:0] used;
  logic [33:0] fat_start;
  fat16bs_pkg::layout_t layout_r, layout_nxt;

  // fields stop changing at byte 35; both stages settle before byte 38
  always_comb begin
    fat_secs_nxt  = 24'(bpb.fat_copies) * 24'(bpb.fat_sectors);
    root_sum      = {1'b0, bpb.root_entries} + ROOT_ROUND;
    root_secs_nxt = 13'(root_sum >> fat16bs_pkg::DIR_SHIFT);
    total_nxt     = (bpb.small_count != 16'd0) ? 32'(bpb.small_count) : bpb.large_count;
  end

  always_comb begin
    used                  = 25'(reserved_r) + 25'(fat_secs_r) + 25'(root_secs_r);
    fat_start             = 34'(reserved_r) << fat16bs_pkg::SECTOR_SHIFT;
    layout_nxt.fat_start  = fat_start;
    layout_nxt.root_start = fat_start + (34'(fat_secs_r) << fat16bs_pkg::SECTOR_SHIFT);
    layout_nxt.data_start = layout_nxt.root_start +
                            (34'(root_secs_r) << fat16bs_pkg::SECTOR_SHIFT);
    layout_nxt.data_secs  = total_r - 32'(used);
  end

  always_ff @(posedge clk) begin
    fat_secs_r  <= fat_secs_nxt;
    root_secs_r <= root_secs_nxt;
    total_r     <= total_nxt;
    reserved_r  <= bpb.reserved;
    layout_r    <= layout_nxt;
  end

  assign layout = layout_r;

endmodule

>>> hdl/fat16bs_outbuf.sv
// Result register with a skid entry
`timescale 1ns / 1ps

module fat16bs_outbuf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  fat16bs_pkg::result_t push_data,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fat16bs_pkg::result_t out_data
);

  logic                 out_valid_r, out_valid_nxt;
  logic                 skid_valid_r, skid_valid_nxt;
  fat16bs_pkg::result_t out_data_r, out_data_nxt;
  fat16bs_pkg::result_t skid_data_r, skid_data_nxt;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
        out_data_nxt  = push_data;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign in_ready  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hdl/fat16_boot_sector_checker.sv
// FAT16 boot sector checker top level
//
//   channel | dir | handshake            | payload
//   in_ch   | in  | valid/ready, item    | data_byte, first_byte
//   out_ch  | out | valid/ready, item    | status, fat/root/data region start,
//           |     |                      | cluster_count
//
// One byte is taken per cycle while in_ch.ready is high; the byte that
// decides a result (byte 0, 2, 12, 13, 35 or 38) registers it for out_ch.
// Region starts and the data sector count come from a two-stage pipeline that
// runs off the captured fields; it settles in the bytes between 35 and 38.
// Reset leaves the block waiting for a byte flagged first_byte.
// A stalled result sits in the output register while a skid entry keeps the
// input open; in_ch.ready drops only when both hold results.
`timescale 1ns / 1ps

module fat16_boot_sector_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  fat16bs_in_if.sink           in_ch,
  fat16bs_out_if.source        out_ch
);

  logic                 acc;
  logic                 in_ready;
  logic                 res_valid;
  fat16bs_pkg::result_t res;
  fat16bs_pkg::result_t out_data;
  fat16bs_pkg::bpb_t    bpb;
  fat16bs_pkg::layout_t layout;

  assign acc         = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  fat16bs_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .data_byte  (in_ch.data_byte),
    .first_byte (in_ch.first_byte),
    .layout     (layout),
    .bpb        (bpb),
    .res_valid  (res_valid),
    .res        (res)
  );

  fat16bs_layout u_layout (
    .clk    (clk),
    .bpb    (bpb),
    .layout (layout)
  );

  fat16bs_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .in_ready  (in_ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  assign out_ch.status            = out_data.status;
  assign out_ch.fat_region_start  = out_data.fat_region_start;
  assign out_ch.root_region_start = out_data.root_region_start;
  assign out_ch.data_region_start = out_data.data_region_start;
  assign out_ch.cluster_count     = out_data.cluster_count;

endmodule

>>> hdl/fat16bs_chk.sv
// Port-level assertions for the FAT16 boot sector checker
`timescale 1ns / 1ps
`include "fat16_boot_sector_checker_macros.svh"

module fat16bs_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [33:0] fat_start,
  input logic [33:0] data_start,
  input logic [31:0] cluster_count
);

  // a result held under backpressure keeps its contents
  `F16BS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(status) && $stable(cluster_count), "result changed while stalled")

  `F16BS_ASSERT(a_status_range, out_valid |-> status <= 3'(fat16bs_pkg::ST_NOT_FAT16), "status code out of range")

  // header errors carry no layout
  `F16BS_ASSERT(a_err_zero, out_valid && status != 3'(fat16bs_pkg::ST_OK) && status != 3'(fat16bs_pkg::ST_NOT_FAT16) |-> fat_start == '0 && data_start == '0 && cluster_count == '0, "error item carries layout")

  `F16BS_ASSERT(a_ok_range, out_valid && status == 3'(fat16bs_pkg::ST_OK) |-> cluster_count >= fat16bs_pkg::MIN_CLUSTERS && cluster_count < fat16bs_pkg::MAX_CLUSTERS_EXCL && data_start >= fat_start, "ok item outside FAT16 range")

  `F16BS_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind fat16_boot_sector_checker fat16bs_chk u_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .status        (out_ch.status),
  .fat_start     (out_ch.fat_region_start),
  .data_start    (out_ch.data_region_start),
  .cluster_count (out_ch.cluster_count)
);

>>> sim/tb_fat16_boot_sector_checker.sv
// Testbench for the FAT16 boot sector checker: byte stream stimulus, BPB predictor, result check
`timescale 1ns / 1ps

module tb_fat16_boot_sector_checker;

  typedef struct {
    logic [7:0] data;
    logic       first;
    bit         drain;  // hold this item until every due result is out
    bit         calm;   // end of run, no idling from here on
  } boot_byte_t;

  logic clk = 1'b0;
  logic rst_n;

  fat16bs_in_if  in_ch();
  fat16bs_out_if out_ch();

  fat16_boot_sector_checker u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  boot_byte_t           byte_q[$];
  fat16bs_pkg::result_t due_results[$];
  int         errors;
  int         counted;
  bit         drain_next;
  logic       in_taken;
  logic       calm_phase;
  int         in_gap, out_gap, in_pct, out_pct, in_tick, out_tick;

  // predictor state
  logic [5:0]  pos;
  logic        closed;
  logic        short_jmp;
  logic [15:0] bps_f;
  logic [7:0]  spc_f;
  logic [15:0] rsvd_f;
  logic [7:0]  nfats_f;
  logic [15:0] root_ent_f;
  logic [15:0] small_cnt;
  logic [15:0] fat_sz_f;
  logic [31:0] large_cnt;

  function automatic void clear_bpb();
    pos        = '0;
    short_jmp  = 1'b0;
    bps_f      = '0;
    spc_f      = '0;
    rsvd_f     = '0;
    nfats_f    = '0;
    root_ent_f = '0;
    small_cnt  = '0;
    fat_sz_f   = '0;
    large_cnt  = '0;
  endfunction

  // Advances the BPB parse by one byte; returns 1 when the byte decides the sector.
  function automatic bit parse_boot_byte(input logic [7:0] b, input logic first,
                                         output fat16bs_pkg::result_t res);
    logic [5:0]           off;
    logic [31:0]          root_secs, fat_secs, total, data_secs, clusters;
    logic [33:0]          fat_start, root_start, data_start;
    fat16bs_pkg::status_t st;
    bit                   hit;
    res = '0;
    hit = 1'b0;
    st  = fat16bs_pkg::ST_OK;
    if (first) begin
      clear_bpb();
      closed = 1'b0;
    end else if (closed) begin
      return 1'b0;
    end
    off = pos;
    pos = pos + 6'd1;
    case (off)
      fat16bs_pkg::OFF_JUMP: begin
        if (b == fat16bs_pkg::JMP_SHORT) short_jmp = 1'b1;
        else if (b == fat16bs_pkg::JMP_NEAR) short_jmp = 1'b0;
        else begin
          hit = 1'b1;
          st  = fat16bs_pkg::ST_BAD_JUMP;
        end
      end
      fat16bs_pkg::OFF_NOP: begin
        if (short_jmp && b != fat16bs_pkg::JMP_NOP) begin
          hit = 1'b1;
          st  = fat16bs_pkg::ST_BAD_JUMP;
        end
      end
      fat16bs_pkg::OFF_BPS_LO: bps_f[7:0] = b;
      fat16bs_pkg::OFF_BPS_HI: begin
        bps_f[15:8] = b;
        if (bps_f != fat16bs_pkg::SECTOR_BYTES) begin
          hit = 1'b1;
          st  = fat16bs_pkg::ST_BAD_SECTOR_SIZE;
        end
      end
      fat16bs_pkg::OFF_SPC: begin
        spc_f = b;
        if (b == 8'd0 || (b & (b - 8'd1)) != 8'd0) begin
          hit = 1'b1;
          st  = fat16bs_pkg::ST_BAD_CLUSTER_SIZE;
        end
      end
      fat16bs_pkg::OFF_RSVD_LO:  rsvd_f[7:0] = b;
      fat16bs_pkg::OFF_RSVD_HI:  rsvd_f[15:8] = b;
      fat16bs_pkg::OFF_NFATS:    nfats_f = b;
      fat16bs_pkg::OFF_ROOT_LO:  root_ent_f[7:0] = b;
      fat16bs_pkg::OFF_ROOT_HI:  root_ent_f[15:8] = b;
      fat16bs_pkg::OFF_SMALL_LO: small_cnt[7:0] = b;
      fat16bs_pkg::OFF_SMALL_HI: small_cnt[15:8] = b;
      fat16bs_pkg::OFF_FATSZ_LO: fat_sz_f[7:0] = b;
      fat16bs_pkg::OFF_FATSZ_HI: fat_sz_f[15:8] = b;
      fat16bs_pkg::OFF_LARGE_B0: large_cnt[7:0] = b;
      fat16bs_pkg::OFF_LARGE_B1: large_cnt[15:8] = b;
      fat16bs_pkg::OFF_LARGE_B2: large_cnt[23:16] = b;
      fat16bs_pkg::OFF_LARGE_B3: begin
        large_cnt[31:24] = b;
        if ((small_cnt != 16'd0) == (large_cnt != 32'd0)) begin
          hit = 1'b1;
          st  = fat16bs_pkg::ST_BAD_SECTOR_COUNT;
        end
      end
      fat16bs_pkg::OFF_LAST: begin
        // root directory sectors round up
        root_secs  = (32'(root_ent_f) * fat16bs_pkg::DIR_ENTRY_BYTES +
                      fat16bs_pkg::SECTOR_BYTES - 1) / fat16bs_pkg::SECTOR_BYTES;
        fat_secs   = 32'(nfats_f) * 32'(fat_sz_f);
        total      = (small_cnt != 16'd0) ? 32'(small_cnt) : large_cnt;
        data_secs  = total - (32'(rsvd_f) + fat_secs + root_secs);
        clusters   = data_secs / 32'(spc_f);
        fat_start  = 34'(rsvd_f) * fat16bs_pkg::SECTOR_BYTES;
        root_start = fat_start + 34'(fat_secs) * fat16bs_pkg::SECTOR_BYTES;
        data_start = root_start + 34'(root_secs) * fat16bs_pkg::SECTOR_BYTES;
        hit = 1'b1;
        st  = (clusters < fat16bs_pkg::MIN_CLUSTERS ||
               clusters >= fat16bs_pkg::MAX_CLUSTERS_EXCL) ?
              fat16bs_pkg::ST_NOT_FAT16 : fat16bs_pkg::ST_OK;
        res.fat_region_start  = fat_start;
        res.root_region_start = root_start;
        res.data_region_start = data_start;
        res.cluster_count     = clusters;
      end
      default: ;
    endcase
    if (hit) begin
      closed     = 1'b1;
      res.status = st;
    end
    return hit;
  endfunction

  task automatic check_field(input string what, input logic [33:0] want,
                             input logic [33:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
      errors++;
    end
  endtask

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 8;
      2: return 30;
      default: return 65;
    endcase
  endfunction

  // predictor on accepted bytes, checker on accepted results
  always @(posedge clk) begin
    fat16bs_pkg::result_t want;
    if (!rst_n) begin
      clear_bpb();
      closed   = 1'b1;
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        if (parse_boot_byte(in_ch.data_byte, in_ch.first_byte, want))
          due_results.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: result with none due, expected nothing actual status %0d",
                   $time, out_ch.status);
          errors++;
        end else begin
          want = due_results.pop_front();
          check_field("status", 34'(want.status), 34'(out_ch.status));
          check_field("fat_region_start", want.fat_region_start, out_ch.fat_region_start);
          check_field("root_region_start", want.root_region_start, out_ch.root_region_start);
          check_field("data_region_start", want.data_region_start, out_ch.data_region_start);
          check_field("cluster_count", 34'(want.cluster_count), 34'(out_ch.cluster_count));
        end
      end
    end
  end

  // byte driver
  always @(negedge clk) begin
    boot_byte_t nb;
    logic       nv, nf;
    logic [7:0] nd;
    int         ng;
    nv = in_ch.valid;
    nd = in_ch.data_byte;
    nf = in_ch.first_byte;
    ng = in_gap;
    if (in_tick == 0) in_pct = pick_pct();
    in_tick = (in_tick + 1) % 50;
    if (rst_n && (!in_ch.valid || in_taken)) begin
      nv = 1'b0;
      if (ng != 0) begin
        ng--;
      end else if (byte_q.size() != 0 && !(byte_q[0].drain && due_results.size() != 0)) begin
        if (!calm_phase && !byte_q[0].calm && $urandom_range(0, 99) < in_pct) begin
          ng = $urandom_range(0, 16);
        end else begin
          nb = byte_q.pop_front();
          nv = 1'b1;
          nd = nb.data;
          nf = nb.first;
          if (nb.calm) calm_phase <= 1'b1;
        end
      end
    end
    in_ch.valid      <= nv;
    in_ch.data_byte  <= nd;
    in_ch.first_byte <= nf;
    in_gap           <= ng;
  end

  // result sink stalls
  always @(negedge clk) begin
    logic nr;
    int   ng;
    ng = out_gap;
    if (out_tick == 0) out_pct = pick_pct();
    out_tick = (out_tick + 1) % 50;
    if (ng != 0) begin
      nr = 1'b0;
      ng--;
    end else if (!calm_phase && $urandom_range(0, 99) < out_pct) begin
      nr = 1'b0;
      ng = $urandom_range(0, 16);
    end else begin
      nr = 1'b1;
    end
    out_ch.ready <= nr;
    out_gap      <= ng;
  end

  task automatic queue_byte(input logic [7:0] d, input logic f, input bit counts);
    boot_byte_t nb;
    nb.data    = d;
    nb.first   = f;
    nb.drain   = drain_next;
    nb.calm    = (counted >= 950);
    drain_next = 1'b0;
    if (counts) counted++;
    byte_q.push_back(nb);
  endtask

  task automatic queue_sector();
    logic [7:0]  sec [39];
    logic [7:0]  spc, copies;
    logic [15:0] rsvd, roots, fats, bps;
    logic [31:0] root_secs, overhead, clusters, total, big_count;
    bit          use_small, cut;
    int          kind, last, n;
    for (int i = 0; i < 39; i++) sec[i] = 8'($urandom);
    if ($urandom_range(0, 39) == 0) drain_next = 1'b1;
    kind = $urandom_range(0, 99);
    if (kind >= 95) begin
      // loose bytes, first flag at random
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) queue_byte(8'($urandom), $urandom_range(0, 3) == 0, 1'b1);
      return;
    end

    spc    = 8'd1 << $urandom_range(0, 7);
    rsvd   = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 32));
    copies = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 2));
    roots  = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'd512;
    fats   = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 256));
    root_secs = (32'(roots) * 32 + 511) / 512;
    overhead  = 32'(rsvd) + 32'(copies) * 32'(fats) + root_secs;
    case ($urandom_range(0, 5))
      1: begin
        case ($urandom_range(0, 3))
          0: clusters = 32'd4084;
          1: clusters = 32'd4085;
          2: clusters = 32'd65524;
          default: clusters = 32'd65525;
        endcase
      end
      2: clusters = $urandom_range(0, 4084);
      3: clusters = $urandom_range(65525, 200000);
      default: clusters = $urandom_range(4085, 65524);
    endcase
    total = overhead + clusters * 32'(spc) + $urandom_range(0, spc - 1);
    if ($urandom_range(0, 9) == 0) total = $urandom;  // wrapping data sector count
    if (total == 32'd0) total = 32'd1;
    use_small = (total < 32'd65536) && ($urandom_range(0, 2) != 0);

    sec[0] = $urandom_range(0, 1) ? fat16bs_pkg::JMP_SHORT : fat16bs_pkg::JMP_NEAR;
    if (sec[0] == fat16bs_pkg::JMP_SHORT) sec[2] = fat16bs_pkg::JMP_NOP;
    {sec[12], sec[11]} = 16'(fat16bs_pkg::SECTOR_BYTES);
    sec[13] = spc;
    {sec[15], sec[14]} = rsvd;
    sec[16] = copies;
    {sec[18], sec[17]} = roots;
    {sec[20], sec[19]} = use_small ? total[15:0] : 16'd0;
    {sec[23], sec[22]} = fats;
    {sec[35], sec[34], sec[33], sec[32]} = use_small ? 32'd0 : total;
    last = 38;
    cut  = 1'b0;

    if (kind >= 60 && kind < 64) begin
      do sec[0] = 8'($urandom);
      while (sec[0] == fat16bs_pkg::JMP_SHORT || sec[0] == fat16bs_pkg::JMP_NEAR);
      last = 0;
    end else if (kind >= 64 && kind < 68) begin
      sec[0] = fat16bs_pkg::JMP_SHORT;
      do sec[2] = 8'($urandom); while (sec[2] == fat16bs_pkg::JMP_NOP);
      last = 2;
    end else if (kind >= 68 && kind < 73) begin
      case ($urandom_range(0, 3))
        0: bps = 16'h0000;
        1: bps = 16'hFFFF;
        2: bps = 16'h0200 ^ (16'h1 << $urandom_range(0, 15));
        default: bps = 16'($urandom);
      endcase
      if (bps == fat16bs_pkg::SECTOR_BYTES) bps = 16'h0201;
      {sec[12], sec[11]} = bps;
      last = 12;
    end else if (kind >= 73 && kind < 78) begin
      case ($urandom_range(0, 2))
        0: spc = 8'd0;
        1: spc = 8'hFF;
        default: do spc = 8'($urandom); while (spc != 8'd0 && (spc & (spc - 8'd1)) == 8'd0);
      endcase
      sec[13] = spc;
      last = 13;
    end else if (kind >= 78 && kind < 85) begin
      if ($urandom_range(0, 1)) begin
        {sec[20], sec[19]} = 16'd0;
        {sec[35], sec[34], sec[33], sec[32]} = 32'd0;
      end else begin
        big_count = $urandom;
        if (big_count == 32'd0) big_count = 32'h8000_0000;
        {sec[20], sec[19]} = 16'($urandom_range(1, 65535));
        {sec[35], sec[34], sec[33], sec[32]} = big_count;
      end
      last = 35;
    end else if (kind >= 85) begin
      // cut short, the next sector restarts mid-stream
      last = $urandom_range(0, 37);
      cut  = 1'b1;
    end

    for (int i = 0; i <= last; i++) queue_byte(sec[i], i == 0, 1'b1);
    if (!cut) begin
      n = $urandom_range(0, 2);
      for (int i = 0; i < n; i++) queue_byte(8'($urandom), 1'b0, 1'b0);
    end
  endtask

  initial begin
    #20_000_000;
    $display("tb_fat16_boot_sector_checker: FAIL");
    $finish;
  end

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = 8'd0;
    in_ch.first_byte = 1'b0;
    out_ch.ready     = 1'b0;
    errors     = 0;
    counted    = 0;
    drain_next = 1'b0;
    calm_phase = 1'b0;
    in_gap     = 0;
    out_gap    = 0;
    in_tick    = 0;
    out_tick   = 0;

    // bytes before any first byte are ignored
    queue_byte(fat16bs_pkg::JMP_SHORT, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    // bad jump opcode, then a byte after the result
    queue_byte(8'h00, 1'b1, 1'b1);
    queue_byte(8'hFF, 1'b0, 1'b0);
    // short jump without the nop
    queue_byte(fat16bs_pkg::JMP_SHORT, 1'b1, 1'b1);
    queue_byte(8'h00, 1'b0, 1'b1);
    queue_byte(8'h91, 1'b0, 1'b1);
    // near jump with a free third byte, restarted mid-stream, then bad sector size
    queue_byte(fat16bs_pkg::JMP_NEAR, 1'b1, 1'b1);
    queue_byte(8'hFF, 1'b0, 1'b1);
    queue_byte(8'h00, 1'b0, 1'b1);
    queue_byte(fat16bs_pkg::JMP_SHORT, 1'b1, 1'b1);
    queue_byte(8'h3C, 1'b0, 1'b1);
    queue_byte(fat16bs_pkg::JMP_NOP, 1'b0, 1'b1);
    for (int i = 3; i <= 10; i++) queue_byte(8'($urandom), 1'b0, 1'b1);
    queue_byte(8'h00, 1'b0, 1'b1);
    queue_byte(8'h03, 1'b0, 1'b1);

    drain_next = 1'b1;
    while (counted < 1100) queue_sector();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    @(posedge clk);
    while (byte_q.size() != 0 || in_ch.valid) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("tb_fat16_boot_sector_checker: PASS");
    end else begin
      $display("tb_fat16_boot_sector_checker: FAIL");
    end
    $finish;
  end

endmodule
